FILE: hw/rtl/pointer_event_translator_defines.svh
// Assertion helpers used by the pointer event translator source.
// Both sample on the rising edge of clk and are switched off while rst_n is low.
`ifndef POINTER_EVENT_TRANSLATOR_DEFINES_SVH
`define POINTER_EVENT_TRANSLATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PET_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pointer event translator: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define PET_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pointer event translator: next-cycle check failed");

`endif

FILE: hw/rtl/pet_pkg.sv
`timescale 1ns / 1ps

package pet_pkg;

  localparam int DIM_W       = 13;
  localparam int CFG_IDX_W   = 1;
  localparam int IN_TDATA_W  = 40;
  localparam int POS_W       = 16;
  localparam int BTN_W       = 8;
  localparam int LOW_BTN_W   = 3;
  localparam int WHEEL_W     = 2;
  localparam int KIND_W      = 2;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'd1;

  localparam logic [BTN_W-1:0] BTN_KEEP_MASK = 8'hF9;
  localparam int BTN4_BIT = 3;
  localparam int BTN5_BIT = 4;

  localparam logic [WHEEL_W-1:0] WHEEL_NONE = 2'b00;
  localparam logic [WHEEL_W-1:0] WHEEL_UP   = 2'b11;
  localparam logic [WHEEL_W-1:0] WHEEL_DOWN = 2'b01;

  typedef enum logic [KIND_W-1:0] {
    KIND_MOVED = 2'd0,
    KIND_DOWN  = 2'd1,
    KIND_UP    = 2'd2,
    KIND_WHEEL = 2'd3
  } event_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_MOTION,
    ST_WHEEL
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: hw/rtl/pointer_event_translator.sv
`timescale 1ns / 1ps
// Pointer event translator. One input word carries a pointer report (position and button
// mask); it yields up to two output words, a motion or button word and a wheel word, the
// final one flagged by out_tlast. The report is taken into the two bit-serial dividers,
// which form one quotient bit per cycle for x and y side by side; when they are done,
// the motion or button word and then the wheel word are loaded into the output register,
// each waiting while the output stalls. A new report is taken as soon as the last result
// has been loaded into the output register, or once the dividers are done if the report
// gives no word.

`include "pointer_event_translator_defines.svh"

module pointer_event_translator
  import pet_pkg::*;
#(
  parameter int COORD_BITS    = 16,
  parameter int FRACTION_BITS = 16,
  localparam int OUT_W        = 2 * (FRACTION_BITS + 1) + LOW_BTN_W + WHEEL_W,
  localparam int OUT_TDATA_W  = ((OUT_W + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // pos_x, pos_y, button_mask
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // abs_x, abs_y, pressed, wheel_delta, zero padding
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // event_kind
  output logic [KIND_W-1:0]      out_tuser,
  output logic                   out_tlast,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [DIM_W-1:0]       cfg_data
);

  localparam int ABS_W = FRACTION_BITS + 1;
  localparam int PAD_W = OUT_TDATA_W - OUT_W;
  localparam int BODY_W = 2 * ABS_W + LOW_BTN_W;

  state_t state_r, state_nxt;

  logic [DIM_W-1:0]     width_r, height_r;
  logic [BTN_W-1:0]     prev_btn_r;
  logic [ABS_W-1:0]     prev_ax_r, prev_ay_r;
  event_kind_t          kind_r;
  logic [LOW_BTN_W-1:0] nb_r;
  logic [WHEEL_W-1:0]   wheel_r;
  logic                 move_only_r;
  logic                 motion_emit_r;

  logic                   out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic [KIND_W-1:0]      out_tuser_r;
  logic                   out_tlast_r;

  logic                 in_acc;
  logic                 out_free;
  logic [BTN_W-1:0]     raw;
  logic [BTN_W-1:0]     btn;
  logic [LOW_BTN_W-1:0] nb, ob;
  event_kind_t          kind;
  logic [WHEEL_W-1:0]   wheel;
  logic                 start;
  logic                 load_motion;
  logic                 load_wheel;
  div_stat_t            x_stat, y_stat;
  logic [ABS_W-1:0]     ax, ay;
  logic [BODY_W-1:0]    out_body;
  logic [WHEEL_W-1:0]   out_wheel;

  assign raw = in_tdata[2*POS_W +: BTN_W];

  always_comb begin
    btn    = raw & BTN_KEEP_MASK;
    btn[2] = raw[1];
    btn[1] = raw[2];
    nb     = btn[LOW_BTN_W-1:0];
    ob     = prev_btn_r[LOW_BTN_W-1:0];
    priority if (nb == '0 && ob != '0) begin
      kind = KIND_UP;
    end else if (nb != '0 && ob == '0) begin
      kind = KIND_DOWN;
    end else begin
      kind = KIND_MOVED;
    end
    priority if (!btn[BTN4_BIT] && prev_btn_r[BTN4_BIT]) begin
      wheel = WHEEL_UP;
    end else if (!btn[BTN5_BIT] && prev_btn_r[BTN5_BIT]) begin
      wheel = WHEEL_DOWN;
    end else begin
      wheel = WHEEL_NONE;
    end
  end

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;
  assign cfg_ready = 1'b1;

  pet_div #(
    .COORD_BITS    (COORD_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_div_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .pos   (in_tdata[COORD_BITS-1:0]),
    .size  (width_r),
    .stat  (x_stat),
    .quot  (ax)
  );

  pet_div #(
    .COORD_BITS    (COORD_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_div_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .pos   (in_tdata[POS_W +: COORD_BITS]),
    .size  (height_r),
    .stat  (y_stat),
    .quot  (ay)
  );

  always_comb begin
    state_nxt   = state_r;
    start       = 1'b0;
    load_motion = 1'b0;
    load_wheel  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && width_r != '0) begin
          start     = 1'b1;
          state_nxt = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (x_stat.done) begin
          state_nxt = ST_MOTION;
        end
      end
      ST_MOTION: begin
        if (!motion_emit_r) begin
          state_nxt = (wheel_r != WHEEL_NONE) ? ST_WHEEL : ST_IDLE;
        end else if (out_free) begin
          load_motion = 1'b1;
          state_nxt   = (wheel_r != WHEEL_NONE) ? ST_WHEEL : ST_IDLE;
        end
      end
      ST_WHEEL: begin
        if (out_free) begin
          load_wheel = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      width_r      <= WIDTH_RESET;
      height_r     <= HEIGHT_RESET;
      prev_btn_r   <= '0;
      prev_ax_r    <= '1;
      prev_ay_r    <= '1;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_SCREEN_WIDTH) begin
          width_r <= cfg_data;
        end
        if (cfg_index == REG_SCREEN_HEIGHT) begin
          height_r <= cfg_data;
        end
      end
      if (start) begin
        prev_btn_r <= btn;
      end
      if (state_r == ST_DIVIDE && x_stat.done) begin
        prev_ax_r <= ax;
        prev_ay_r <= ay;
      end
      if (load_motion || load_wheel) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
    if (start) begin
      kind_r      <= kind;
      nb_r        <= nb;
      wheel_r     <= wheel;
      move_only_r <= (kind == KIND_MOVED) && (nb == ob);
    end
    if (state_r == ST_DIVIDE && x_stat.done) begin
      motion_emit_r <= !move_only_r || (ax != prev_ax_r) || (ay != prev_ay_r);
    end
    if (load_motion) begin
      out_tdata_r <= {{PAD_W{1'b0}}, WHEEL_NONE, nb_r, ay, ax};
      out_tuser_r <= kind_r;
      out_tlast_r <= (wheel_r == WHEEL_NONE);
    end else if (load_wheel) begin
      out_tdata_r <= {{PAD_W{1'b0}}, wheel_r, {LOW_BTN_W{1'b0}}, {ABS_W{1'b0}}, {ABS_W{1'b0}}};
      out_tuser_r <= KIND_WHEEL;
      out_tlast_r <= 1'b1;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

  assign out_body  = out_tdata_r[BODY_W-1:0];
  assign out_wheel = out_tdata_r[BODY_W +: WHEEL_W];

  `PET_ASSERT_NEXT(a_div_started, in_tvalid && in_tready && width_r != '0, x_stat.busy)
  `PET_ASSERT_IMPL(a_div_lockstep, 1'b1, x_stat.done == y_stat.done && x_stat.busy == y_stat.busy)
  `PET_ASSERT_IMPL(a_wheel_word, out_tvalid && out_tuser == KIND_WHEEL, out_body == '0 && out_wheel != WHEEL_NONE && out_tlast)
  `PET_ASSERT_IMPL(a_motion_word, out_tvalid && out_tuser != KIND_WHEEL, out_wheel == WHEEL_NONE)

endmodule

FILE: hw/rtl/pet_div.sv
`timescale 1ns / 1ps

module pet_div
  import pet_pkg::*;
#(
  parameter int COORD_BITS    = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [COORD_BITS-1:0]    pos,
  input  logic [DIM_W-1:0]         size,
  output div_stat_t                stat,
  output logic [FRACTION_BITS:0]   quot
);

  localparam int N     = COORD_BITS + FRACTION_BITS;
  localparam int CNT_W = $clog2(N);
  localparam logic [FRACTION_BITS:0] ABS_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [N-1:0]           dvd_r, dvd_nxt;
  logic [DIM_W-1:0]       rem_r, rem_nxt;
  logic [FRACTION_BITS:0] q_r, q_nxt;
  logic                   ovf_r, ovf_nxt;

  logic [DIM_W:0] trial;
  logic [DIM_W:0] diff;
  logic           ge;

  assign trial = {rem_r, dvd_r[N-1]};
  assign diff  = trial - {1'b0, size};
  assign ge    = trial >= {1'b0, size};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    ovf_nxt  = ovf_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = {pos, {FRACTION_BITS{1'b0}}};
      rem_nxt  = '0;
      q_nxt    = '0;
      ovf_nxt  = 1'b0;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[N-2:0], 1'b0};
      rem_nxt = ge ? diff[DIM_W-1:0] : trial[DIM_W-1:0];
      q_nxt   = {q_r[FRACTION_BITS-1:0], ge};
      ovf_nxt = ovf_r | q_r[FRACTION_BITS];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(N - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    ovf_r <= ovf_nxt;
  end

  // Quotients above one saturate to exactly one.
  assign quot = (ovf_r || (q_r[FRACTION_BITS] && (|q_r[FRACTION_BITS-1:0]))) ? ABS_ONE : q_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule
